// ----- rtl/crc32_word_packed_byte_stream_macros.svh -----
// Assertion macros for the CRC word packer RTL.
// Depends on nothing; each user module provides clk and rst_n.
`ifndef CRC32_WORD_PACKED_BYTE_STREAM_MACROS_SVH
`define CRC32_WORD_PACKED_BYTE_STREAM_MACROS_SVH

// Same-cycle implication, checked on every edge out of reset.
`define CRCW_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every edge out of reset.
`define CRCW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/crcw_pkg.sv -----
// Shared types, constants and the CRC-32/MPEG-2 word fold function.
// Depends on nothing; used by every module of the block.
package crcw_pkg;

    localparam logic [31:0] CrcPoly = 32'h04C1_1DB7;
    localparam logic [31:0] CrcInit = 32'hFFFF_FFFF;

    // Queue between packer and CRC engine.
    localparam int QDepth = 2;
    localparam int QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
    localparam int QCntW  = $clog2(QDepth + 1);

    // One word beat handed from the packer to the CRC engine.
    typedef struct packed {
        logic [31:0] word;
        logic        last;
    } crcw_beat_t;

    typedef logic [31:0][31:0] crcw_mask_t;

    // Build the 32x32 XOR matrix of a 32-bit MSB-first fold.
    // Row i holds the input bits whose XOR gives output bit i.
    function automatic crcw_mask_t crcw_fold_masks();
        crcw_mask_t  m;
        logic [31:0] v;
        m = '0;
        for (int j = 0; j < 32; j++)
        begin
            v = 32'h1 << j;
            for (int k = 0; k < 32; k++)
            begin
                v = v[31] ? ((v << 1) ^ CrcPoly) : (v << 1);
            end
            for (int i = 0; i < 32; i++)
            begin
                m[i][j] = v[i];
            end
        end
        return m;
    endfunction

    localparam crcw_mask_t FoldMask = crcw_fold_masks();

    // Fold one word into the CRC: one parity tree per output bit.
    function automatic logic [31:0] crcw_fold(input logic [31:0] crc,
                                              input logic [31:0] word);
        logic [31:0] c;
        logic [31:0] r;
        c = crc ^ word;
        for (int i = 0; i < 32; i++)
        begin
            r[i] = ^(c & FoldMask[i]);
        end
        return r;
    endfunction

endpackage

// ----- rtl/crc32_word_packed_byte_stream.sv -----
// CRC-32/MPEG-2 over a byte stream: top level joining packer, queue and CRC engine.
// Depends on crcw_pkg, crcw_pack, crcw_fifo and crcw_fold.
//
// Usage:
//   Input channel: drive data_byte and last_byte with push high; a beat is
//   taken on each edge where push is high and full is low. Bytes are packed
//   MSB-first into 32-bit words; last_byte marks the end of a message, and a
//   partial final word is zero padded before it is folded in.
//   Result channel: while empty is low, crc_result holds the CRC of the
//   oldest finished message; it is taken on an edge where pop is high.
//   Throughput: one byte per cycle, sustained while full is low, set by the packer
//   and the combinational word fold in the CRC engine.
//   Result path: the closing word enters the queue when its last byte is
//   taken; the fold then reads it from the queue head and writes the result
//   register, which drives crc_result and can then be popped.
//   Stall: if results are not popped, closing words wait in the queue; once
//   it holds two word beats, full rises and input stops.
//   Reset: rst_n is asynchronous, active low; it drops all pending bytes,
//   queued words and results, and re-arms the CRC to all ones.
module crc32_word_packed_byte_stream
    import crcw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] crc_result
);

    logic       byte_accept;
    logic       q_push;
    crcw_beat_t q_in;
    logic       q_full;
    logic       q_pop;
    crcw_beat_t q_head;
    logic       q_empty;

    assign full        = q_full;
    assign byte_accept = push && !q_full;

    // Front: byte packing.
    crcw_pack u_pack (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_accept (byte_accept),
        .data_byte   (data_byte),
        .last_byte   (last_byte),
        .q_push      (q_push),
        .q_beat      (q_in)
    );

    // Word beat queue.
    crcw_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_beat (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    // Back: CRC fold and result slot.
    crcw_fold u_fold (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_head     (q_head),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .crc_result (crc_result),
        .empty      (empty),
        .pop        (pop)
    );

endmodule

// ----- rtl/crcw_pack.sv -----
// Front end: accepts bytes and packs them MSB-first into 32-bit word beats.
// Depends on crcw_pkg.
module crcw_pack
    import crcw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_accept,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output logic       q_push,
    output crcw_beat_t q_beat
);

    logic [23:0] pend_bytes_reg;
    logic [23:0] pend_bytes_next;
    logic [1:0]  pend_cnt_reg;
    logic [1:0]  pend_cnt_next;
    logic [31:0] word;

    // Merge the new byte below the pending ones.
    always_comb
    begin
        case (pend_cnt_reg)
            2'd0:    word = {data_byte, 24'h0};
            2'd1:    word = {pend_bytes_reg[23:16], data_byte, 16'h0};
            2'd2:    word = {pend_bytes_reg[23:8], data_byte, 8'h0};
            default: word = {pend_bytes_reg, data_byte};
        endcase
    end

    // A beat leaves when the word fills or the message ends.
    assign q_push      = byte_accept && (last_byte || (pend_cnt_reg == 2'd3));
    assign q_beat.word = word;
    assign q_beat.last = last_byte;

    // Pending byte bookkeeping.
    always_comb
    begin
        pend_bytes_next = pend_bytes_reg;
        pend_cnt_next   = pend_cnt_reg;
        if (byte_accept)
        begin
            if (last_byte || (pend_cnt_reg == 2'd3))
            begin
                pend_bytes_next = '0;
                pend_cnt_next   = '0;
            end
            else
            begin
                pend_bytes_next = word[31:8];
                pend_cnt_next   = pend_cnt_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_bytes_reg <= '0;
            pend_cnt_reg   <= '0;
        end
        else
        begin
            pend_bytes_reg <= pend_bytes_next;
            pend_cnt_reg   <= pend_cnt_next;
        end
    end

endmodule

// ----- rtl/crcw_fifo.sv -----
// Short queue of word beats between the packer and the CRC engine.
// Depends on crcw_pkg and the assertion macro header.
`include "crc32_word_packed_byte_stream_macros.svh"

module crcw_fifo
    import crcw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  crcw_beat_t push_beat,
    output logic       full,
    input  logic       pop,
    output crcw_beat_t head,
    output logic       empty
);

    crcw_beat_t        slot_reg [QDepth];
    logic [QPtrW-1:0]  wr_ptr_reg;
    logic [QPtrW-1:0]  wr_ptr_next;
    logic [QPtrW-1:0]  rd_ptr_reg;
    logic [QPtrW-1:0]  rd_ptr_next;
    logic [QCntW-1:0]  count_reg;
    logic [QCntW-1:0]  count_next;
    logic              do_push;
    logic              do_pop;

    localparam logic [QCntW-1:0] CntFull = QCntW'(QDepth);
    localparam logic [QPtrW-1:0] PtrLast = QPtrW'(QDepth - 1);

    assign full    = (count_reg == CntFull);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slot_reg[rd_ptr_reg];

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrLast) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrLast) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage slots.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_beat;
        end
    end

    // The packer must never offer a beat to a full queue.
    `CRCW_ASSERT_IMPL(a_no_push_full, push, !full, "beat pushed into full queue")
    // A lone push grows the occupancy by one.
    `CRCW_ASSERT_NEXT(a_push_grows, do_push && !do_pop,
                      count_reg == $past(count_reg) + 1'b1, "push lost")
    // A lone pop shrinks the occupancy by one.
    `CRCW_ASSERT_NEXT(a_pop_shrinks, do_pop && !do_push,
                      count_reg == $past(count_reg) - 1'b1, "pop lost")

endmodule

// ----- rtl/crcw_fold.sv -----
// Back end: folds word beats into the CRC and holds the finished result.
// Depends on crcw_pkg.
module crcw_fold
    import crcw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  crcw_beat_t  q_head,
    input  logic        q_empty,
    output logic        q_pop,
    output logic [31:0] crc_result,
    output logic        empty,
    input  logic        pop
);

    logic [31:0] crc_accum_reg;
    logic [31:0] crc_accum_next;
    logic [31:0] res_crc_reg;
    logic [31:0] res_crc_next;
    logic        res_valid_reg;
    logic        res_valid_next;
    logic [31:0] folded;
    logic        res_take;

    assign res_take = pop && res_valid_reg;

    // A closing beat needs the result slot free or being drained.
    assign q_pop  = !q_empty && (!q_head.last || !res_valid_reg || res_take);
    assign folded = crcw_fold(crc_accum_reg, q_head.word);

    // Accumulator and result slot update.
    always_comb
    begin
        crc_accum_next = crc_accum_reg;
        res_crc_next   = res_crc_reg;
        res_valid_next = res_valid_reg && !res_take;
        if (q_pop)
        begin
            if (q_head.last)
            begin
                crc_accum_next = CrcInit;
                res_crc_next   = folded;
                res_valid_next = 1'b1;
            end
            else
            begin
                crc_accum_next = folded;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_accum_reg <= CrcInit;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            crc_accum_reg <= crc_accum_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_crc_reg <= res_crc_next;
    end

    assign crc_result = res_crc_reg;
    assign empty      = !res_valid_reg;

endmodule

// ----- bench/crcw_result_checker.sv -----
// Checker for the CRC-32/MPEG-2 byte stream block: predicts each message CRC and compares it.
// Depends on nothing but the block's port signals; instantiated by crc32_word_packed_byte_stream_test.
module crcw_result_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic        empty,
    input  logic        pop,
    input  logic [31:0] crc_result,
    output int          crc_outstanding,
    output int          mismatch_count
);

    localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
    localparam logic [31:0] CRC_SEED = 32'hFFFF_FFFF;

    // Predicted state of the packer and the running CRC.
    logic [31:0] crc_running;
    logic [23:0] partial_word;
    logic [1:0]  partial_count;
    logic [31:0] message_crc_q[$];

    // Shift one 32-bit word through the CRC register, most significant bit first.
    function automatic logic [31:0] crc_fold_word(input logic [31:0] crc,
                                                  input logic [31:0] word);
        logic [31:0] c;
        c = crc ^ word;
        for (int k = 0; k < 32; k++)
        begin
            c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    // Sample both channels at the rising edge; results are matched before new beats
    // are predicted, so a beat and a result taken at the same edge stay in order.
    always @(posedge clk or negedge rst_n)
    begin : track
        logic [31:0] word_v;
        logic [31:0] want;
        if (!rst_n)
        begin
            crc_running     = CRC_SEED;
            partial_word    = '0;
            partial_count   = '0;
            message_crc_q.delete();
            crc_outstanding = 0;
            mismatch_count  = 0;
        end
        else
        begin
            // Result side: compare with the oldest finished message.
            if (pop && !empty)
            begin
                if (message_crc_q.size() == 0)
                begin
                    $error("crc_result: expected no beat, actual %h", crc_result);
                    mismatch_count++;
                end
                else
                begin
                    want = message_crc_q.pop_front();
                    if (crc_result !== want)
                    begin
                        $error("crc_result: expected %h, actual %h", want, crc_result);
                        mismatch_count++;
                    end
                end
            end

            // Input side: place the byte in its lane of the current word.
            if (push && !full)
            begin
                word_v = {partial_word, 8'h00}
                       | ({24'h0, data_byte} << (24 - 8 * int'(partial_count)));
                if (last_byte)
                begin
                    // Final byte: fold the zero-padded word and re-arm.
                    message_crc_q.push_back(crc_fold_word(crc_running, word_v));
                    crc_running   = CRC_SEED;
                    partial_word  = '0;
                    partial_count = '0;
                end
                else if (partial_count == 2'd3)
                begin
                    // Fourth byte completes the word; fold it with no result.
                    crc_running   = crc_fold_word(crc_running, word_v);
                    partial_word  = '0;
                    partial_count = '0;
                end
                else
                begin
                    partial_word  = word_v[31:8];
                    partial_count = partial_count + 2'd1;
                end
            end
            crc_outstanding = message_crc_q.size();
        end
    end

endmodule

// ----- bench/crc32_word_packed_byte_stream_test.sv -----
// Testbench top for crc32_word_packed_byte_stream: clock, reset, byte stimulus and the verdict.
// Depends on the block's RTL and on crcw_result_checker, which predicts and compares results.
module crc32_word_packed_byte_stream_test;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 80;
    localparam int DIR_BYTES   = 24;
    localparam int DIR_MSGS    = 7;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic        empty;
    logic        pop;
    logic [31:0] crc_result;

    int crc_outstanding;
    int mismatches;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_req = 1'b0;

    // Directed messages: lone extreme bytes, every partial-word length at the end,
    // an exact full word, and messages that cross one word boundary.
    logic [7:0] dir_bytes [DIR_BYTES] = '{
        8'h00,
        8'hFF,
        8'hFF, 8'hFF,
        8'h00, 8'h00, 8'h00,
        8'hFF, 8'hFF, 8'hFF, 8'hFF,
        8'h80, 8'h01, 8'h7F, 8'hFE, 8'h55,
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'hAA
    };
    int dir_lens [DIR_MSGS] = '{1, 1, 2, 3, 4, 5, 8};

    crc32_word_packed_byte_stream u_top
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .empty      (empty),
        .pop        (pop),
        .crc_result (crc_result)
    );

    crcw_result_checker u_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .data_byte       (data_byte),
        .last_byte       (last_byte),
        .empty           (empty),
        .pop             (pop),
        .crc_result      (crc_result),
        .crc_outstanding (crc_outstanding),
        .mismatch_count  (mismatches)
    );

    always #2 clk = ~clk;

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("crc32_word_packed_byte_stream_test: FAIL");
            $finish;
        end
    end

    // Result side: random stalls, plus a long hold-off when the stimulus asks for one.
    initial
    begin
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
            begin
                pop <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Offer one byte after a random gap and hold it until the block takes the beat.
    task automatic send_byte(input logic [7:0] value, input logic is_last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push      <= 1'b1;
        data_byte <= value;
        last_byte <= is_last;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // Whole messages of random length and content until the byte budget is spent.
    // Most are short; some span many words.
    task automatic send_random_messages(input int byte_budget, input int max_len);
        int         sent;
        int         len;
        logic [7:0] value;
        sent = 0;
        while (sent < byte_budget)
        begin
            len = ($urandom_range(9) < 7) ? $urandom_range(1, 9) : $urandom_range(10, max_len);
            for (int i = 0; i < len; i++)
            begin
                case ($urandom_range(9))
                    0: value = 8'h00;
                    1: value = 8'hFF;
                    default: value = 8'($urandom);
                endcase
                send_byte(value, i == len - 1);
            end
            sent += len;
        end
    endtask

    initial
    begin : stimulus
        int pos;
        rst_n     = 1'b0;
        push      = 1'b0;
        data_byte = 8'h00;
        last_byte = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed messages with no idling on either side.
        pos = 0;
        for (int m = 0; m < DIR_MSGS; m++)
        begin
            for (int i = 0; i < dir_lens[m]; i++)
            begin
                send_byte(dir_bytes[pos], i == dir_lens[m] - 1);
                pos++;
            end
        end
        send_random_messages(90, 40);

        // Receiver holds off while short messages keep coming, so the block fills
        // up and raises full; then the sender waits for every result to drain.
        hold_req = 1'b1;
        send_random_messages(30, 3);
        push <= 1'b0;
        wait (crc_outstanding == 0);
        @(negedge clk);

        // Idle phases: sender gaps, receiver stalls, then both.
        send_idle_pct = 64;
        send_random_messages(90, 40);
        send_idle_pct  = 0;
        recv_stall_pct = 64;
        send_random_messages(90, 40);
        send_idle_pct  = 19;
        recv_stall_pct = 19;
        send_random_messages(90, 40);

        // Drain and watch a little longer for stray results.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        push <= 1'b0;
        wait (crc_outstanding == 0);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("crc32_word_packed_byte_stream_test: PASS");
        end
        else
        begin
            $display("crc32_word_packed_byte_stream_test: FAIL");
        end
        $finish;
    end

endmodule
